[hw/rtl/sv39_page_table_walker_unit_assert.svh]
// assertion macros shared by the walker rtl
`ifndef SV39_PAGE_TABLE_WALKER_UNIT_ASSERT_SVH
`define SV39_PAGE_TABLE_WALKER_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// condition holds in the same cycle
`define SV39PTW_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition holds in the following cycle
`define SV39PTW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define SV39PTW_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define SV39PTW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

[hw/rtl/sv39ptw_pkg.sv]
`timescale 1ns / 1ps

package sv39ptw_pkg;

    localparam int VA_W       = 39;
    localparam int PPN_W      = 44;
    localparam int PA_W       = 56;
    localparam int EIDX_W     = 12;
    localparam int ENTRY_W    = 64;
    localparam int FAULT_W    = 3;
    localparam int LEVEL_BITS = 9;
    localparam int PAGE_SHIFT = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 44;

    // page table entry layout
    localparam int PTE_V_BIT   = 0;
    localparam int PTE_U_BIT   = 4;
    localparam int PTE_PPN_LSB = 10;
    localparam int PTE_PPN_MSB = PTE_PPN_LSB + PPN_W - 1;

    // commands
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_XLATE = 1'b1;

    // fault codes
    localparam logic [FAULT_W-1:0] FAULT_NONE    = 3'd0;
    localparam logic [FAULT_W-1:0] FAULT_VA      = 3'd1;
    localparam logic [FAULT_W-1:0] FAULT_PTR     = 3'd2;
    localparam logic [FAULT_W-1:0] FAULT_LEAF    = 3'd3;
    localparam logic [FAULT_W-1:0] FAULT_OUTSIDE = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROOT_PPN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_PPN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BYPASS   = 2'd2;

    // walk levels, top first
    localparam logic [1:0] LEVEL_TOP = 2'd2;
    localparam logic [1:0] LEVEL_MID = 2'd1;
    localparam logic [1:0] LEVEL_LEAF = 2'd0;

    typedef struct packed {
        logic               command;
        logic [VA_W-1:0]    va;
        logic [EIDX_W-1:0]  entry_index;
        logic [ENTRY_W-1:0] entry_value;
    } ptw_in_t;

    typedef struct packed {
        logic [PA_W-1:0]    pa;
        logic [FAULT_W-1:0] fault;
    } ptw_out_t;

    typedef struct packed {
        logic [PPN_W-1:0] root_ppn;
        logic [PPN_W-1:0] table_base_ppn;
        logic             identity_bypass;
    } ptw_cfg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DONE
    } ptw_state_t;

endpackage

[hw/rtl/sv39ptw_table_mem.sv]
`timescale 1ns / 1ps

module sv39ptw_table_mem #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic                        clk,
    input  logic                        we,
    input  logic [AW-1:0]               waddr,
    input  logic [sv39ptw_pkg::ENTRY_W-1:0] wdata,
    input  logic                        re,
    input  logic [AW-1:0]               raddr,
    output logic [sv39ptw_pkg::ENTRY_W-1:0] rdata
);
    import sv39ptw_pkg::*;

    logic [ENTRY_W-1:0] mem [0:DEPTH-1];
    logic [ENTRY_W-1:0] rdata_reg;

    // contents undefined until written, no clearing
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/sv39ptw_walker.sv]
`timescale 1ns / 1ps
`include "sv39_page_table_walker_unit_assert.svh"

module sv39ptw_walker #(
    parameter int TABLE_PAGES = 8,
    parameter int AW          = 12
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  sv39ptw_pkg::ptw_cfg_t   cfg,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  sv39ptw_pkg::ptw_in_t    in_data,
    output logic                    res_valid,
    input  logic                    res_ready,
    output sv39ptw_pkg::ptw_out_t   res_data,
    output logic                    mem_we,
    output logic [AW-1:0]           mem_waddr,
    output logic [sv39ptw_pkg::ENTRY_W-1:0] mem_wdata,
    output logic                    mem_re,
    output logic [AW-1:0]           mem_raddr,
    input  logic [sv39ptw_pkg::ENTRY_W-1:0] mem_rdata
);
    import sv39ptw_pkg::*;

    localparam int MEM_WORDS = TABLE_PAGES * 512;
    localparam int PW        = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;

    ptw_state_t          state_reg, state_next;
    logic [1:0]          level_reg, level_next;
    logic [VA_W-1:0]     va_reg, va_next;
    ptw_out_t            res_reg, res_next;

    logic                accept;
    logic [PPN_W-1:0]    chk_ppn;
    logic [LEVEL_BITS-1:0] chk_idx;
    logic [PPN_W:0]      chk_diff;
    logic                chk_outside;
    logic                pte_v;
    logic                pte_u;
    logic [PPN_W-1:0]    pte_ppn;

    assign accept   = in_valid && (state_reg == ST_IDLE);
    assign in_stall = (state_reg != ST_IDLE);

    assign pte_v   = mem_rdata[PTE_V_BIT];
    assign pte_u   = mem_rdata[PTE_U_BIT];
    assign pte_ppn = mem_rdata[PTE_PPN_MSB:PTE_PPN_LSB];

    // table page to read next: the root when starting, else the pointer just read
    always_comb
    begin
        if (state_reg == ST_IDLE)
        begin
            chk_ppn = cfg.root_ppn;
            chk_idx = in_data.va[38:30];
        end
        else
        begin
            chk_ppn = pte_ppn;
            chk_idx = (level_reg == LEVEL_TOP) ? va_reg[29:21] : va_reg[20:12];
        end
    end

    // page must lie within [base, base + TABLE_PAGES)
    assign chk_diff    = {1'b0, chk_ppn} - {1'b0, cfg.table_base_ppn};
    assign chk_outside = chk_diff[PPN_W] ||
                         (chk_diff[PPN_W-1:0] >= PPN_W'(TABLE_PAGES));
    assign mem_raddr   = AW'({chk_diff[PW-1:0], chk_idx});

    assign mem_waddr = AW'(in_data.entry_index);
    assign mem_wdata = in_data.entry_value;

    always_comb
    begin
        state_next = state_reg;
        level_next = level_reg;
        va_next    = va_reg;
        res_next   = res_reg;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        res_valid  = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    va_next        = in_data.va;
                    level_next     = LEVEL_TOP;
                    res_next.pa    = '0;
                    res_next.fault = FAULT_NONE;
                    state_next     = ST_DONE;
                    if (in_data.command == CMD_WRITE)
                    begin
                        mem_we = (32'(in_data.entry_index) < MEM_WORDS);
                    end
                    else if (in_data.va[VA_W-1])
                    begin
                        res_next.fault = FAULT_VA;
                    end
                    else if (cfg.identity_bypass)
                    begin
                        res_next.pa = PA_W'(in_data.va);
                    end
                    else if (chk_outside)
                    begin
                        res_next.fault = FAULT_OUTSIDE;
                    end
                    else
                    begin
                        mem_re     = 1'b1;
                        state_next = ST_WALK;
                    end
                end
            end

            ST_WALK:
            begin
                if (level_reg == LEVEL_LEAF)
                begin
                    state_next = ST_DONE;
                    if (pte_v && pte_u)
                    begin
                        res_next.pa = {pte_ppn, va_reg[PAGE_SHIFT-1:0]};
                    end
                    else
                    begin
                        res_next.fault = FAULT_LEAF;
                    end
                end
                else if (!pte_v)
                begin
                    res_next.fault = FAULT_PTR;
                    state_next     = ST_DONE;
                end
                else if (chk_outside)
                begin
                    res_next.fault = FAULT_OUTSIDE;
                    state_next     = ST_DONE;
                end
                else
                begin
                    mem_re     = 1'b1;
                    level_next = level_reg - 2'd1;
                end
            end

            ST_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign res_data = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            level_reg <= LEVEL_TOP;
        end
        else
        begin
            state_reg <= state_next;
            level_reg <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        va_reg  <= va_next;
        res_reg <= res_next;
    end

    // no write and read in the same cycle
    `SV39PTW_ASSERT_SAME(a_no_rw_overlap, clk, rst_n, mem_we, !mem_re,
        "table write and read in the same cycle")

    // every walk cycle consumes a read issued the cycle before
    `SV39PTW_ASSERT_SAME(a_walk_has_read, clk, rst_n, state_reg == ST_WALK, $past(mem_re),
        "walk step without a pending table read")

    // a write item answers with a clean zero result next
    `SV39PTW_ASSERT_NEXT(a_write_result, clk, rst_n,
        accept && (in_data.command == CMD_WRITE),
        (state_reg == ST_DONE) && (res_reg.fault == FAULT_NONE) && (res_reg.pa == '0),
        "write item did not give a zero result")

endmodule

[hw/rtl/sv39_page_table_walker_unit.sv]
`timescale 1ns / 1ps
`include "sv39_page_table_walker_unit_assert.svh"

// sv39 page table walker with a local table memory of TABLE_PAGES pages of
// 512 64-bit entries, covering physical pages table_base_ppn onwards. a write
// item stores one entry (indexes beyond the memory are dropped) and answers
// pa 0, fault 0. a translate item walks three 9-bit levels from root_ppn,
// following any entry with V set as a pointer (no superpages); the last entry
// needs V and U, and pa is its ppn with the page offset appended. faults: 1 va
// at or above 2^38 (checked before bypass), 2 invalid pointer entry, 3 leaf
// lacking V or U, 4 table page outside the memory. identity_bypass returns
// va unchanged. items are handled one at a time: a write, a fault found before
// the first read, or a bypass goes straight to the result; a full walk first
// makes three dependent reads of the single table memory, each registered.
// a finished item sits in the output register while the next item is
// accepted and walked. the table memory is not cleared at reset and an entry
// must be written before a walk reads it. configuration must be written only
// while the block is idle; the user is bound, the block does not enforce it.
module sv39_page_table_walker_unit #(
    parameter int TABLE_PAGES = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  sv39ptw_pkg::ptw_in_t              in_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output sv39ptw_pkg::ptw_out_t             out_data,
    input  logic                              cfg_we,
    input  logic [sv39ptw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sv39ptw_pkg::CFG_DATA_W-1:0] cfg_data
);
    import sv39ptw_pkg::*;

    localparam int MEM_WORDS = TABLE_PAGES * 512;
    localparam int AW        = $clog2(MEM_WORDS);

    // configuration registers
    ptw_cfg_t           cfg_reg;

    // result item register towards the output channel
    logic               out_valid_reg;
    ptw_out_t           out_data_reg;

    logic               res_valid;
    logic               res_ready;
    ptw_out_t           res_data;

    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [ENTRY_W-1:0] mem_wdata;
    logic               mem_re;
    logic [AW-1:0]      mem_raddr;
    logic [ENTRY_W-1:0] mem_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ROOT_PPN: cfg_reg.root_ppn        <= cfg_data[PPN_W-1:0];
                CFG_BASE_PPN: cfg_reg.table_base_ppn  <= cfg_data[PPN_W-1:0];
                CFG_BYPASS:   cfg_reg.identity_bypass <= cfg_data[0];
                default:      cfg_reg <= cfg_reg;
            endcase
        end
    end

    // walker control: sequencing of the walk and fault checks
    sv39ptw_walker #(
        .TABLE_PAGES (TABLE_PAGES),
        .AW          (AW)
    ) u_walker (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    // page table storage, one write and one registered read port
    sv39ptw_table_mem #(
        .DEPTH (MEM_WORDS),
        .AW    (AW)
    ) u_table_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // output register takes a new item when empty or being drained
    assign res_ready = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_data_reg <= res_data;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // a handed-over result always shows up on the output
    `SV39PTW_ASSERT_NEXT(a_result_lands, clk, rst_n, res_valid && res_ready,
        out_valid_reg && (out_data_reg == $past(res_data)),
        "result item lost between walker and output register")

    // faulting items carry a zero address
    `SV39PTW_ASSERT_SAME(a_fault_zero_pa, clk, rst_n,
        out_valid_reg && (out_data_reg.fault != FAULT_NONE), out_data_reg.pa == '0,
        "faulting result with non-zero pa")

endmodule
